// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0] PAD_MARK = 8'h80;

   // one input item as it travels through the queue
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [31:0] h0;
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
      logic        ovf;
   } digest_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      if (r < 7'd20) return K0;
      else if (r < 7'd40) return K1;
      else if (r < 7'd60) return K2;
      else return K3;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      if (r < 7'd20) return (b & c) | (~b & d);
      else if (r >= 7'd40 && r < 7'd60) return (b & c) | (b & d) | (c & d);
      else return b ^ c ^ d;
   endfunction

endpackage

// ===== rtl/sha1_queue.sv =====
module sha1_queue
   import sha1_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   // two-entry queue between the byte front end and the hash engine
   item_type   mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue full but ready");
   a_count: assert property (@(posedge clock) disable iff (reset)
      push && !pop && cnt_ff == 2'd0 |=> cnt_ff == 2'd1) else $error("count slip");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready && !push |=> out_valid) else $error("queue lost item");
`endif
endmodule

// ===== rtl/sha1_engine.sv =====
module sha1_engine
   import sha1_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output digest_type out_digest
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROUND = 5'b00010,
      S_PAD   = 5'b00100,
      S_ADD   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] w_ff [16];           // message schedule window
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  rnd_ff;
   logic [5:0]  fill_ff;
   logic [63:0] cnt_ff;
   logic        ovf_ff;
   logic        fin_ff;              // compressing a final block
   logic        more_ff;             // a length block follows
   logic        tail_ff;             // a full padding block follows a full data block
   logic [5:0]  pidx_ff;             // padding write position
   logic        res_ff;
   digest_type  dig_ff;

   logic [31:0] wcur, wnew, tsum;
   logic [3:0]  widx;
   logic [63:0] cnt_nx;
   logic        take;
   logic        emit;

   assign in_ready   = state_ff == S_IDLE;
   assign take       = in_valid && in_ready;
   assign out_valid  = res_ff;
   assign out_digest = dig_ff;
   assign cnt_nx     = cnt_ff + 64'd8;
   // hold in the output state until the previous digest has left
   assign emit       = state_ff == S_OUT && (!res_ff || out_ready);

   assign widx = rnd_ff[3:0];
   assign wnew = {w_ff[(widx + 4'd13)] ^ w_ff[(widx + 4'd8)] ^ w_ff[(widx + 4'd2)]
                  ^ w_ff[widx]} << 1
               | {31'd0, w_ff[(widx + 4'd13)][31] ^ w_ff[(widx + 4'd8)][31]
                  ^ w_ff[(widx + 4'd2)][31] ^ w_ff[widx][31]};
   assign wcur = rnd_ff < 7'd16 ? w_ff[widx] : wnew;
   assign tsum = {a_ff[26:0], a_ff[31:27]} + round_f(rnd_ff, b_ff, c_ff, d_ff) + e_ff
                 + wcur + round_k(rnd_ff);

   // put one byte into the schedule window, big-endian within the word
   function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                            input logic [7:0] v);
      logic [31:0] r;
      r = w;
      case (pos)
         2'd0:    r[31:24] = v;
         2'd1:    r[23:16] = v;
         2'd2:    r[15:8]  = v;
         default: r[7:0]   = v;
      endcase
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (take && in_item.last && !(in_item.present && !ovf_ff
                                  && fill_ff == 6'd63)) begin
                     state_in = (ovf_ff || (in_item.present && cnt_nx == 64'd0))
                                ? S_OUT : S_PAD;
                  end else if (take && in_item.present && !ovf_ff
                               && fill_ff == 6'd63) begin
                     state_in = S_ROUND;
                  end
         S_PAD:   if (pidx_ff == 6'd63) state_in = S_ROUND;
         S_ROUND: if (rnd_ff == 7'd79) state_in = S_ADD;
         S_ADD:   state_in = tail_ff ? S_PAD
                           : fin_ff ? (more_ff ? S_PAD : S_OUT) : S_IDLE;
         S_OUT:   state_in = emit ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (in_item.present && !ovf_ff) begin
                  w_ff[fill_ff[5:2]] <= put_byte(w_ff[fill_ff[5:2]], fill_ff[1:0],
                                                 in_item.data);
               end
               a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
               d_ff <= h_ff[3]; e_ff <= h_ff[4];
               rnd_ff <= 7'd0;
               pidx_ff <= (in_item.present && !ovf_ff) ? fill_ff + 6'd1 : fill_ff;
               more_ff <= 1'b0;
               fin_ff <= in_item.last;
               tail_ff <= in_item.last && in_item.present && !ovf_ff
                          && fill_ff == 6'd63 && cnt_nx != 64'd0;
            end
         end
         S_PAD: begin
            // first pass writes the mark, later positions get zeros or length
            if (!more_ff && pidx_ff == fill_ff) begin
               w_ff[pidx_ff[5:2]] <= put_byte(w_ff[pidx_ff[5:2]], pidx_ff[1:0], PAD_MARK);
            end else if (pidx_ff >= 6'd56 && !(fill_ff >= 6'd56 && !more_ff)) begin
               w_ff[pidx_ff[5:2]] <= put_byte(w_ff[pidx_ff[5:2]], pidx_ff[1:0],
                                              cnt_ff[6'(63 - 8*pidx_ff[2:0]) -: 8]);
            end else begin
               w_ff[pidx_ff[5:2]] <= put_byte(w_ff[pidx_ff[5:2]], pidx_ff[1:0], 8'd0);
            end
            if (pidx_ff == 6'd63) begin
               more_ff <= !more_ff && fill_ff >= 6'd56;
               a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
               d_ff <= h_ff[3]; e_ff <= h_ff[4];
               rnd_ff <= 7'd0;
            end
            pidx_ff <= pidx_ff + 6'd1;
         end
         S_ROUND: begin
            if (rnd_ff >= 7'd16) w_ff[widx] <= wnew;
            a_ff <= tsum; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
            d_ff <= c_ff; e_ff <= d_ff;
            rnd_ff <= rnd_ff + 7'd1;
         end
         S_ADD: begin
            tail_ff <= 1'b0;
            if (more_ff) begin
               fill_ff <= 6'd0;
               pidx_ff <= 6'd0;
            end
         end
         default: ;
      endcase
      if (emit) begin
         dig_ff.h0 <= ovf_ff ? 32'd0 : h_ff[0];
         dig_ff.h1 <= ovf_ff ? 32'd0 : h_ff[1];
         dig_ff.h2 <= ovf_ff ? 32'd0 : h_ff[2];
         dig_ff.h3 <= ovf_ff ? 32'd0 : h_ff[3];
         dig_ff.h4 <= ovf_ff ? 32'd0 : h_ff[4];
         dig_ff.ovf <= ovf_ff;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff <= 1'b0;
         fill_ff <= 6'd0;
         cnt_ff <= 64'd0;
         ovf_ff <= 1'b0;
         tail_ff <= 1'b0;
         h_ff[0] <= H0_INIT; h_ff[1] <= H1_INIT; h_ff[2] <= H2_INIT;
         h_ff[3] <= H3_INIT; h_ff[4] <= H4_INIT;
      end else begin
         state_ff <= state_in;
         if (emit) res_ff <= 1'b1;
         else if (out_ready) res_ff <= 1'b0;
         if (take && in_item.present && !ovf_ff) begin
            fill_ff <= fill_ff + 6'd1;
            cnt_ff <= cnt_nx;
            if (cnt_nx == 64'd0) ovf_ff <= 1'b1;
         end
         if (state_ff == S_ADD) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
         end
         if (emit) begin
            fill_ff <= 6'd0;
            cnt_ff <= 64'd0;
            ovf_ff <= 1'b0;
            h_ff[0] <= H0_INIT; h_ff[1] <= H1_INIT; h_ff[2] <= H2_INIT;
            h_ff[3] <= H3_INIT; h_ff[4] <= H4_INIT;
         end
      end
   end

`ifndef SYNTHESIS
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND && rnd_ff == 7'd79 |=> state_ff == S_ADD)
      else $error("round count slip");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !in_ready) else $error("accept while busy");
   a_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> out_valid) else $error("digest lost");
`endif
endmodule

// ===== rtl/sha1_message_hash.sv =====
// SHA-1 hash of a byte stream.
// req channel: one item per transfer; tdata is the message byte, tuser[0]
// marks the byte as present, tlast closes the message (pad and hash).
// rsp channel: one transfer per message with the five digest words in tdata
// (h0 lowest) and tuser[0] set when the bit count wrapped (digest zero).
// A two-entry queue decouples the req side from the hash engine, so bytes
// are taken while a result waits.
// The engine takes bytes only while idle; every 64th byte starts an 80-round
// compression at one round per cycle, followed by an add step, and no byte is
// taken until it is done.
// Unless the bit count has wrapped, closing a message pads the byte positions
// left in each final block (one or two), compresses each final block and
// registers the digest.
// Synchronous reset returns the chaining words to the initial values and
// empties the queue. While rsp_tready is low the digest holds and the engine
// stops at the next message end, before its digest is registered.
module sha1_message_hash
   import sha1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // message_byte
   input  logic         req_tuser,   // byte_present
   input  logic         req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // digest_h0, h1, h2, h3, h4
   output logic         rsp_tuser    // length_overflow
);
   item_type   qin, qout;
   logic       q_valid, q_ready;
   digest_type dig;

   assign qin = '{data: req_tdata, present: req_tuser, last: req_tlast};

   sha1_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(qin),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(qout)
   );

   sha1_engine u_engine (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(qout),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_digest(dig)
   );

   assign rsp_tdata = {dig.h4, dig.h3, dig.h2, dig.h1, dig.h0};
   assign rsp_tuser = dig.ovf;
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import sha1_pkg::*;

   localparam int MSG_ITEMS = 1700;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [159:0] EMPTY_DIGEST =
      {32'hafd80709, 32'h95601890, 32'h3255bfef, 32'h5e6b4b0d, 32'hda39a3ee};
   localparam logic [159:0] ABC_DIGEST =
      {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         req_tuser = 1'b0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic         rsp_tuser;

   typedef struct {
      logic [7:0]   data;
      logic         present;
      logic         last;
      logic         typed;
      logic [159:0] digest;
   } hash_row_type;

   hash_row_type directed_rows[10];
   digest_type digest_queue[$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   bit         idle_on = 1'b1;

   // predictor state
   logic [31:0] chain[5];
   logic [7:0]  msg_block[64];
   int          fill_count;
   logic [63:0] bit_total;
   logic        wrapped;

   sha1_message_hash dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void restart_hash();
      chain[0] = H0_INIT;
      chain[1] = H1_INIT;
      chain[2] = H2_INIT;
      chain[3] = H3_INIT;
      chain[4] = H4_INIT;
      fill_count = 0;
      bit_total = '0;
      wrapped = 1'b0;
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void compress_chain();
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = K0;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K2;
         end else begin
            f = b ^ c ^ d; k = K3;
         end
         t = rol(a, 5) + f + e + w[i] + k;
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      fill_count = 0;
   endfunction

   // absorb one transfer; returns 1 with the digest when the message closes
   function automatic bit absorb_item(input logic [7:0] data, input logic present,
                                      input logic last, output digest_type dg);
      int pos;
      dg = '0;
      if (present && !wrapped) begin
         msg_block[fill_count] = data;
         fill_count++;
         bit_total += 64'd8;
         if (bit_total == 64'd0) wrapped = 1'b1;
         if (fill_count == 64) compress_chain();
      end
      if (!last) return 1'b0;
      if (wrapped) begin
         dg.ovf = 1'b1;
      end else begin
         pos = fill_count;
         msg_block[pos++] = PAD_MARK;
         if (pos > 56) begin
            while (pos < 64) msg_block[pos++] = 8'h00;
            compress_chain();
            pos = 0;
         end
         while (pos < 56) msg_block[pos++] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[56+i] = bit_total[63-8*i -: 8];
         compress_chain();
         dg = {chain[0], chain[1], chain[2], chain[3], chain[4], 1'b0};
      end
      restart_hash();
      return 1'b1;
   endfunction

   task automatic send_item(input logic [7:0] data, input logic present,
                            input logic last, input logic typed, input logic [159:0] digest);
      digest_type dg;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= present;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (absorb_item(data, present, last, dg)) begin
         if (typed)
            dg = {digest[31:0], digest[63:32], digest[95:64], digest[127:96],
                  digest[159:128], 1'b0};
         digest_queue.push_back(dg);
      end
   endtask

   // receiver drops rsp_tready in random bursts, started only while idle_on is set
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest transfer %h ovf %b", $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_tdata[31:0] !== want.h0 || rsp_tdata[63:32] !== want.h1 ||
                rsp_tdata[95:64] !== want.h2 || rsp_tdata[127:96] !== want.h3 ||
                rsp_tdata[159:128] !== want.h4 || rsp_tuser !== want.ovf) begin
               $display("%0t: digest mismatch expected %h %h %h %h %h ovf %b", $time,
                        want.h0, want.h1, want.h2, want.h3, want.h4, want.ovf);
               $display("%0t:                 actual   %h %h %h %h %h ovf %b", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                        rsp_tdata[127:96], rsp_tdata[159:128], rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int sent;
      int msg_len;
      int msg_index;
      int pick;
      logic [7:0] b;
      bit close_empty;
      int boundary[8] = '{55, 56, 57, 63, 64, 65, 119, 120};

      // idle item, empty message, "abc", byte extremes, idle item, close without a byte, one-byte message
      directed_rows[0] = '{8'hff, 1'b0, 1'b0, 1'b0, '0};
      directed_rows[1] = '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST};
      directed_rows[2] = '{8'h61, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[3] = '{8'h62, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[4] = '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST};
      directed_rows[5] = '{8'h00, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[6] = '{8'hff, 1'b1, 1'b0, 1'b0, '0};
      directed_rows[7] = '{8'h5a, 1'b0, 1'b0, 1'b0, '0};
      directed_rows[8] = '{8'h80, 1'b0, 1'b1, 1'b0, '0};
      directed_rows[9] = '{8'hff, 1'b1, 1'b1, 1'b0, '0};

      restart_hash();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].data, directed_rows[i].present, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].digest);

      sent = 0;
      msg_index = 0;
      while (sent < MSG_ITEMS) begin
         idle_on = (sent < MSG_ITEMS - 250) && ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 6) msg_len = $urandom_range(0, 70);
         else if (pick < 8) msg_len = boundary[$urandom_range(0, 7)];
         else msg_len = $urandom_range(71, 200);
         close_empty = (msg_len == 0) || ($urandom_range(0, 3) == 0);
         for (int i = 0; i < msg_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
               sent++;
            end
            b = 8'($urandom_range(0, 255));
            send_item(b, 1'b1, !close_empty && (i == msg_len - 1), 1'b0, '0);
            sent++;
         end
         if (close_empty) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            sent++;
         end
         msg_index++;
         // after the fifth message, hold the sender until the engine has drained
         if (msg_index == 5) begin
            req_tvalid <= 1'b0;
            while (digest_queue.size() > 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      idle_on = 1'b0;

      while (digest_queue.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sha1_pkg.sv
rtl/sha1_queue.sv
rtl/sha1_engine.sv
rtl/sha1_message_hash.sv
dv/testbench.sv
